// ===== src/mss_pkg.sv =====
package mss_pkg;

	typedef struct packed {
		logic insert;
		logic shift;
	} mss_ctrl_t;

endpackage

// ===== src/mss_cell.sv =====
module mss_cell
	import mss_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 7,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  mss_ctrl_t             ctrl,
	input  logic [CNT_W-1:0]      fill,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] prev_val,
	input  logic                  prev_lt,
	input  logic [DATA_WIDTH-1:0] next_val,
	output logic [DATA_WIDTH-1:0] val,
	output logic                  lt
);

	logic [DATA_WIDTH-1:0] val_q;

	// empty cells count as larger than any value
	always_comb begin
		lt = (fill <= CNT_W'(INDEX)) || ($signed(din) < $signed(val_q));
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (lt) begin
				val_q <= prev_lt ? prev_val : din;
			end
		end else if (ctrl.shift) begin
			val_q <= next_val;
		end
	end

	assign val = val_q;

endmodule

// ===== src/merge_sorter_unit.sv =====
// Sorter for runs of signed values, smallest first.
// Feed channel: value/last on feed_valid, held off by feed_stall. One beat per
// cycle is taken while a run is loading; the beat with last set closes the run.
// Each beat is placed into a row of cells in order as it arrives, so the row
// stays sorted; the place of each beat is found by the compare across the row.
// After the closing beat feed_stall rises and the row drains from its head,
// one result beat per cycle on result_valid/result_stall unless stalled. The
// closing beat moves the state register to drain; the head value then loads
// into the result register. last_out marks the final result, overflow is set
// on it when more than MAX_ELEMENTS values came in and the excess was dropped.
// A stalled result holds; the row holds too until the result register frees.
// feed_stall falls once the final result is in the output register.
// Reset empties the row, clears the drop mark and the output valid.
module merge_sorter_unit
	import mss_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64,
	parameter int DATA_WIDTH   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  feed_valid,
	output logic                  feed_stall,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  last,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [DATA_WIDTH-1:0] sorted_value,
	output logic                  last_out,
	output logic                  overflow
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      fill_q;
	logic                  drop_q;
	logic                  res_valid_q;
	logic [DATA_WIDTH-1:0] res_value_q;
	logic                  res_last_q;
	logic                  res_ovf_q;

	logic                  feed_acc;
	logic                  full;
	logic                  load_out;
	logic                  final_beat;
	mss_ctrl_t             ctrl;

	logic [DATA_WIDTH-1:0] cell_val [MAX_ELEMENTS];
	logic                  cell_lt  [MAX_ELEMENTS];

	assign feed_stall  = (state_q != ST_LOAD);
	assign feed_acc    = feed_valid && !feed_stall;
	assign full        = (fill_q == CNT_W'(MAX_ELEMENTS));
	assign load_out    = (state_q == ST_DRAIN) && (!res_valid_q || !result_stall);
	assign final_beat  = (fill_q == CNT_W'(1));
	assign ctrl.insert = feed_acc && !full;
	assign ctrl.shift  = load_out;

	genvar i;
	generate
		for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] prev_v;
			logic                  prev_l;
			logic [DATA_WIDTH-1:0] next_v;
			if (i == 0) begin : g_head
				assign prev_v = value;
				assign prev_l = 1'b0;
			end else begin : g_body
				assign prev_v = cell_val[i-1];
				assign prev_l = cell_lt[i-1];
			end
			if (i == MAX_ELEMENTS - 1) begin : g_tail
				assign next_v = cell_val[i];
			end else begin : g_mid
				assign next_v = cell_val[i+1];
			end
			mss_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.CNT_W      (CNT_W),
				.INDEX      (i)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.fill     (fill_q),
				.din      (value),
				.prev_val (prev_v),
				.prev_lt  (prev_l),
				.next_val (next_v),
				.val      (cell_val[i]),
				.lt       (cell_lt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			drop_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (feed_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
						if (last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (load_out) begin
						fill_q <= fill_q - CNT_W'(1);
						if (final_beat) begin
							state_q <= ST_LOAD;
							drop_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_value_q <= cell_val[0];
			res_last_q  <= final_beat;
			res_ovf_q   <= final_beat && drop_q;
		end
	end

	assign result_valid = res_valid_q;
	assign sorted_value = res_value_q;
	assign last_out     = res_last_q;
	assign overflow     = res_ovf_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ELEMENTS))
		else $error("fill beyond capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> fill_q != '0)
		else $error("drain with empty row");

	a_final_returns: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && final_beat |=> state_q == ST_LOAD && fill_q == '0 && !drop_q)
		else $error("run not closed after final result");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && fill_q > CNT_W'(1) |-> $signed(cell_val[0]) <= $signed(cell_val[1]))
		else $error("row out of order");
`endif

endmodule
